FILE: hw/rtl/assert_macros.svh
// assertion macros for the checker file kwsc_checker.sv
// no dependencies; clock and reset are passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle, consequent in the next
`define KWSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kwsc assertion failed");

// free-form property under clock and reset
`define KWSC_ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("kwsc assertion failed");

`endif

FILE: hw/rtl/kwsc_pkg.sv
// shared constants, types and the letter test of the keyword substitution cipher
// no dependencies
`default_nettype none

package kwsc_pkg;

    localparam int ALPHABET_LETTERS = 26;
    localparam int IDX_W  = $clog2(ALPHABET_LETTERS);
    localparam int FILL_W = $clog2(ALPHABET_LETTERS + 1);

    localparam logic [2:0] FN_BEGIN   = 3'd0;
    localparam logic [2:0] FN_KEY     = 3'd1;
    localparam logic [2:0] FN_FINISH  = 3'd2;
    localparam logic [2:0] FN_ENCRYPT = 3'd3;
    localparam logic [2:0] FN_DECRYPT = 3'd4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_LETTERS - 1);

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } letter_t;

    // command to the alphabet store
    typedef struct packed {
        logic             clear;
        logic             place;
        logic [IDX_W-1:0] idx;
    } kwsc_cmd_t;

    function automatic letter_t letter_index(input logic [7:0] c);
        letter_t    r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            d     = c - CHAR_UPPER_A;
            r.hit = 1'b1;
            r.idx = d[IDX_W-1:0];
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            d     = c - CHAR_LOWER_A;
            r.hit = 1'b1;
            r.idx = d[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/keyword_substitution_cipher_top.sv
// keyword substitution cipher, top level: sequencer, result register and skid stage
// depends on kwsc_pkg and kwsc_alpha
//
//  channel  | signals                      | direction | carries
//  ---------+------------------------------+-----------+-------------------------
//  input    | in_valid, in_stall           | in        | func, in_char
//  output   | out_valid, out_stall         | out       | out_char (text items only)
//
// begin, key char, text and unknown items are each taken on their input transfer
// a text result that finds the output register empty or draining sits in it from the cycle after its input transfer
// finish key: taken on its transfer, then a scan from A to Z with input stalled, one alphabet
// letter per cycle through the shared placement unit
// a result that finds the output register full and stalled parks in a skid register;
// input then stalls until the output transfer frees the output register
// asynchronous active-low reset restores the identity alphabet at once
`default_nettype none

module keyword_substitution_cipher_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] func,
    input  wire logic [7:0] in_char,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] out_char
);

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // taking items
        ST_SCAN = 3'b010,   // finish key: walking A to Z
        ST_HOLD = 3'b100    // result parked, waiting for the output register
    } state_t;

    state_t                      state_reg, state_next;
    logic [kwsc_pkg::IDX_W-1:0]  scan_reg, scan_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  out_char_reg, out_char_next;
    logic [7:0]                  pend_reg, pend_next;

    logic                        in_xfer;
    logic                        out_xfer;
    logic                        is_text;
    logic [7:0]                  res_char;
    kwsc_pkg::letter_t           chr_info;
    kwsc_pkg::kwsc_cmd_t         cmd;
    logic [kwsc_pkg::IDX_W-1:0]  look_val;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;

    assign chr_info = kwsc_pkg::letter_index(in_char);
    assign is_text  = (func == kwsc_pkg::FN_ENCRYPT) || (func == kwsc_pkg::FN_DECRYPT);

    // the placement unit serves key chars and every step of the finish scan
    always_comb
    begin
        cmd       = '0;
        cmd.clear = in_xfer && (func == kwsc_pkg::FN_BEGIN);
        if (state_reg == ST_SCAN)
        begin
            cmd.place = 1'b1;
            cmd.idx   = scan_reg;
        end
        else
        begin
            cmd.place = in_xfer && (func == kwsc_pkg::FN_KEY) && chr_info.hit;
            cmd.idx   = chr_info.idx;
        end
    end

    kwsc_alpha u_alpha (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .look_idx (chr_info.idx),
        .look_inv (func == kwsc_pkg::FN_DECRYPT),
        .look_val (look_val)
    );

    // letters come out upper case, everything else passes through
    assign res_char = chr_info.hit ? (kwsc_pkg::CHAR_UPPER_A + 8'(look_val)) : in_char;

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        out_char_next  = out_char_reg;
        pend_next      = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && is_text)
                begin
                    if (!out_valid_reg || out_xfer)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = res_char;
                    end
                    else
                    begin
                        // output register busy and stalled: park the result
                        pend_next  = res_char;
                        state_next = ST_HOLD;
                    end
                end
                else if (in_xfer && (func == kwsc_pkg::FN_FINISH))
                begin
                    scan_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + kwsc_pkg::IDX_W'(1);
                if (scan_reg == kwsc_pkg::LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_HOLD:
            begin
                if (out_xfer)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        pend_reg     <= pend_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/kwsc_alpha.sv
// alphabet store: forward and inverse letter maps, used-letter set, fill position
// depends on kwsc_pkg
`default_nettype none

module kwsc_alpha (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire kwsc_pkg::kwsc_cmd_t       cmd,
    input  wire logic [kwsc_pkg::IDX_W-1:0] look_idx,
    input  wire logic                      look_inv,
    output logic      [kwsc_pkg::IDX_W-1:0] look_val
);

    logic [kwsc_pkg::IDX_W-1:0]  letter_map_reg  [kwsc_pkg::ALPHABET_LETTERS];
    logic [kwsc_pkg::IDX_W-1:0]  inverse_map_reg [kwsc_pkg::ALPHABET_LETTERS];
    logic [kwsc_pkg::ALPHABET_LETTERS-1:0] used_reg;
    logic [kwsc_pkg::FILL_W-1:0] fill_reg;
    logic                        do_place;

    // placement: letter unused and alphabet not yet full
    assign do_place = cmd.place && !used_reg[cmd.idx]
                      && (fill_reg < kwsc_pkg::FILL_W'(kwsc_pkg::ALPHABET_LETTERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kwsc_pkg::ALPHABET_LETTERS; i++)
            begin
                letter_map_reg[i]  <= kwsc_pkg::IDX_W'(i);
                inverse_map_reg[i] <= kwsc_pkg::IDX_W'(i);
            end
            used_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.clear)
        begin
            used_reg <= '0;
            fill_reg <= '0;
        end
        else if (do_place)
        begin
            letter_map_reg[fill_reg[kwsc_pkg::IDX_W-1:0]] <= cmd.idx;
            inverse_map_reg[cmd.idx] <= fill_reg[kwsc_pkg::IDX_W-1:0];
            used_reg[cmd.idx] <= 1'b1;
            fill_reg <= fill_reg + kwsc_pkg::FILL_W'(1);
        end
    end

    assign look_val = look_inv ? inverse_map_reg[look_idx] : letter_map_reg[look_idx];

endmodule

`default_nettype wire

FILE: hw/rtl/kwsc_checker.sv
// port-level checker of the keyword substitution cipher, bound to the top level
// depends on kwsc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module kwsc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [2:0] func,
    input wire logic [7:0] in_char,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_char
);

    logic in_xfer;
    logic out_room;
    logic out_wait;
    logic finish_xfer;
    logic enc_lower;
    logic dec_low;
    logic out_upper;

    assign in_xfer     = in_valid && !in_stall;
    assign out_room    = !out_valid || !out_stall;
    assign out_wait    = out_valid && out_stall;
    assign finish_xfer = in_xfer && (func == kwsc_pkg::FN_FINISH);
    assign enc_lower   = in_xfer && out_room && (func == kwsc_pkg::FN_ENCRYPT)
                         && (in_char >= kwsc_pkg::CHAR_LOWER_A)
                         && (in_char <= kwsc_pkg::CHAR_LOWER_Z);
    assign dec_low     = in_xfer && out_room && (func == kwsc_pkg::FN_DECRYPT)
                         && (in_char < kwsc_pkg::CHAR_UPPER_A);
    assign out_upper   = (out_char >= kwsc_pkg::CHAR_UPPER_A)
                         && (out_char <= kwsc_pkg::CHAR_UPPER_Z);

    // stalled result holds
    `KWSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_char))

    // finish key starts the alphabet scan
    `KWSC_ASSERT_PROP(a_finish_busy, clk, rst_n, finish_xfer |-> ##1 in_stall)

    // an encrypted lower-case letter leaves as an upper-case letter
    `KWSC_ASSERT_NEXT(a_enc_upper, clk, rst_n, enc_lower, out_valid && out_upper)

    // bytes below 'A' pass through decryption
    `KWSC_ASSERT_NEXT(a_dec_pass, clk, rst_n, dec_low, out_valid && out_char == $past(in_char))

endmodule

bind keyword_substitution_cipher_top kwsc_checker u_kwsc_checker (.*);

`default_nettype wire

FILE: sim/keyword_substitution_cipher_top_tb.sv
// self-checking testbench for keyword_substitution_cipher_top: keyed alphabet build and text lookup
// depends on kwsc_pkg for function codes and alphabet constants, and on the rtl top level
`default_nettype none

module keyword_substitution_cipher_top_tb;

    localparam int          MAX_GAP   = 17;
    localparam int unsigned HOLD_OFF  = 400;     // long receiver hold, fills result and skid stages
    localparam int          DRAIN     = 60;      // finish key walks 26 slots, plus pipeline slack
    localparam int          RUN_LIMIT = 600000;
    localparam int          N_ITEMS   = 1650;

    // one queued input transfer plus the idle cycles the sender spends before it
    typedef struct {
        logic [2:0]  fn;
        logic [7:0]  ch;
        int unsigned gap;
    } cipher_item_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [2:0] func      = '0;
    logic [7:0] in_char   = '0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_char;

    keyword_substitution_cipher_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .in_char   (in_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char)
    );

    // stimulus and scoreboard storage
    cipher_item_t pending_items [$];
    logic [7:0]   expected_text [$];
    int           mismatches  = 0;
    int           stim_count  = 0;
    bit           tx_burst    = 1'b0;
    int unsigned  tx_wait     = 0;
    int unsigned  rx_wait     = 0;
    int unsigned  drained     = 0;
    int unsigned  cycle_count = 0;

    // shadow cipher state: forward alphabet, its inverse, letters placed and next free slot
    logic [kwsc_pkg::IDX_W-1:0]            alpha_fwd [kwsc_pkg::ALPHABET_LETTERS];
    logic [kwsc_pkg::IDX_W-1:0]            alpha_inv [kwsc_pkg::ALPHABET_LETTERS];
    logic [kwsc_pkg::ALPHABET_LETTERS-1:0] key_used;
    logic [kwsc_pkg::FILL_W-1:0]           key_fill;

    // ---------------------------------------------------------------
    // cipher predictor
    // ---------------------------------------------------------------

    // append one letter to the alphabet unless already placed or the alphabet is full
    task automatic place_cipher_letter(input logic [kwsc_pkg::IDX_W-1:0] idx);
        if (!key_used[idx]
            && key_fill < kwsc_pkg::FILL_W'(kwsc_pkg::ALPHABET_LETTERS))
        begin
            alpha_fwd[key_fill] = idx;
            alpha_inv[idx]      = key_fill[kwsc_pkg::IDX_W-1:0];
            key_used[idx]       = 1'b1;
            key_fill            = key_fill + kwsc_pkg::FILL_W'(1);
        end
    endtask

    // update the shadow state for one accepted item, queue its ciphertext or plaintext byte
    task automatic apply_cipher_item(input logic [2:0] fn, input logic [7:0] ch);
        logic                       is_letter;
        logic [kwsc_pkg::IDX_W-1:0] idx;
        logic [7:0]                 d;
        logic [7:0]                 res;
        is_letter = 1'b0;
        idx       = '0;
        d         = '0;
        // only plain ascii a-z / A-Z count as letters, bytes from 128 up never do
        if (ch >= kwsc_pkg::CHAR_UPPER_A && ch <= kwsc_pkg::CHAR_UPPER_Z)
        begin
            d         = ch - kwsc_pkg::CHAR_UPPER_A;
            is_letter = 1'b1;
        end
        else if (ch >= kwsc_pkg::CHAR_LOWER_A && ch <= kwsc_pkg::CHAR_LOWER_Z)
        begin
            d         = ch - kwsc_pkg::CHAR_LOWER_A;
            is_letter = 1'b1;
        end
        idx = d[kwsc_pkg::IDX_W-1:0];
        case (fn)
            kwsc_pkg::FN_BEGIN:
            begin
                // maps keep their entries, only the placement bookkeeping restarts
                key_used = '0;
                key_fill = '0;
            end
            kwsc_pkg::FN_KEY:
            begin
                if (is_letter)
                    place_cipher_letter(idx);
            end
            kwsc_pkg::FN_FINISH:
            begin
                for (int i = 0; i < kwsc_pkg::ALPHABET_LETTERS; i++)
                    place_cipher_letter(kwsc_pkg::IDX_W'(i));
            end
            kwsc_pkg::FN_ENCRYPT:
            begin
                res = is_letter ? kwsc_pkg::CHAR_UPPER_A + 8'(alpha_fwd[idx]) : ch;
                expected_text.push_back(res);
            end
            kwsc_pkg::FN_DECRYPT:
            begin
                res = is_letter ? kwsc_pkg::CHAR_UPPER_A + 8'(alpha_inv[idx]) : ch;
                expected_text.push_back(res);
            end
            default:
            begin
                // unknown codes are dropped by the block
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic queue_item(input logic [2:0] fn, input logic [7:0] ch);
        cipher_item_t it;
        it.fn  = fn;
        it.ch  = ch;
        it.gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        pending_items.push_back(it);
        if (fn <= kwsc_pkg::FN_DECRYPT)
            stim_count++;
    endtask

    // letter in either case
    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = kwsc_pkg::CHAR_UPPER_A
            + 8'($urandom_range(0, kwsc_pkg::ALPHABET_LETTERS - 1));
        if ($urandom_range(0, 1) == 1)
            c = c + (kwsc_pkg::CHAR_LOWER_A - kwsc_pkg::CHAR_UPPER_A);
        return c;
    endfunction

    // encrypt or decrypt, mostly letters, some arbitrary bytes
    task automatic queue_text();
        logic [7:0] c;
        c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : random_letter();
        queue_item(($urandom_range(0, 1) == 1) ? kwsc_pkg::FN_ENCRYPT
                                               : kwsc_pkg::FN_DECRYPT, c);
    endtask

    // ---------------------------------------------------------------
    // clock and reset
    // ---------------------------------------------------------------

    initial
    begin
        forever
            #6 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // stimulus: directed opening, then random key sessions, noise and broken sessions
    // ---------------------------------------------------------------

    initial
    begin : build_stimulus
        int unsigned kind;
        int unsigned key_len;
        int unsigned start;
        int unsigned stride;
        int unsigned n_text;
        logic [7:0]  c;

        // identity alphabet straight after reset, field extremes
        queue_item(kwsc_pkg::FN_ENCRYPT, kwsc_pkg::CHAR_UPPER_A);
        queue_item(kwsc_pkg::FN_DECRYPT, kwsc_pkg::CHAR_LOWER_Z);
        queue_item(kwsc_pkg::FN_ENCRYPT, 8'h00);
        queue_item(kwsc_pkg::FN_DECRYPT, 8'hFF);
        // unknown codes, all func bits set on the last one
        queue_item(3'd5, kwsc_pkg::CHAR_UPPER_A);
        queue_item(3'd6, 8'h55);
        queue_item(3'd7, 8'hFF);
        // key char with no begin, then text against the half-rewritten map
        queue_item(kwsc_pkg::FN_KEY, 8'h51);
        queue_item(kwsc_pkg::FN_ENCRYPT, kwsc_pkg::CHAR_LOWER_A);
        // fresh key: duplicate letter, bytes bordering the letter ranges, high byte
        queue_item(kwsc_pkg::FN_BEGIN, 8'h00);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_LOWER_Z);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_UPPER_Z);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_UPPER_A - 8'd1);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_UPPER_Z + 8'd1);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_LOWER_A - 8'd1);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_LOWER_Z + 8'd1);
        queue_item(kwsc_pkg::FN_KEY, 8'hC1);
        queue_item(kwsc_pkg::FN_KEY, kwsc_pkg::CHAR_LOWER_A);
        queue_item(kwsc_pkg::FN_FINISH, 8'h00);
        // finish repeated and key after finish change nothing
        queue_item(kwsc_pkg::FN_FINISH, 8'hFF);
        queue_item(kwsc_pkg::FN_KEY, 8'h4D);
        queue_item(kwsc_pkg::FN_ENCRYPT, kwsc_pkg::CHAR_UPPER_Z);
        queue_item(kwsc_pkg::FN_DECRYPT, kwsc_pkg::CHAR_UPPER_A);
        queue_item(kwsc_pkg::FN_ENCRYPT, 8'h7F);
        queue_item(kwsc_pkg::FN_DECRYPT, 8'h6D);

        while (stim_count < N_ITEMS)
        begin
            kind     = $urandom_range(0, 9);
            tx_burst = ($urandom_range(0, 3) == 0);
            if (kind < 7)
            begin
                // well-formed session: begin, keyword, finish, text
                queue_item(kwsc_pkg::FN_BEGIN, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 7) == 0)
                begin
                    // full alphabet by a stride permutation, extra keys must bounce off
                    start  = $urandom_range(0, kwsc_pkg::ALPHABET_LETTERS - 1);
                    stride = 2 * $urandom_range(0, 12) + 1;
                    if (stride == 13)
                        stride = 1;
                    for (int i = 0; i < kwsc_pkg::ALPHABET_LETTERS; i++)
                    begin
                        c = kwsc_pkg::CHAR_UPPER_A
                            + 8'((start + i * stride) % kwsc_pkg::ALPHABET_LETTERS);
                        if ($urandom_range(0, 1) == 1)
                            c = c + (kwsc_pkg::CHAR_LOWER_A - kwsc_pkg::CHAR_UPPER_A);
                        queue_item(kwsc_pkg::FN_KEY, c);
                    end
                    key_len = $urandom_range(1, 4);
                end
                else
                    key_len = $urandom_range(0, 12);
                repeat (key_len)
                begin
                    c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                   : random_letter();
                    queue_item(kwsc_pkg::FN_KEY, c);
                end
                queue_item(kwsc_pkg::FN_FINISH, 8'($urandom_range(0, 255)));
                n_text = $urandom_range(1, 30);
                repeat (n_text)
                    queue_text();
            end
            else if (kind < 9)
            begin
                // noise: any code, any byte
                repeat ($urandom_range(1, 12))
                    queue_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                // broken session: key never finished, text hits the partial map
                if ($urandom_range(0, 1) == 1)
                    queue_item(kwsc_pkg::FN_BEGIN, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 8))
                    queue_item(kwsc_pkg::FN_KEY, random_letter());
                repeat ($urandom_range(1, 10))
                    queue_text();
            end
        end
    end

    // ---------------------------------------------------------------
    // driver: presents queued items, holds payload while stalled
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : drive_inputs
        cipher_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                // transfer done, next item goes out at once only if it has no gap
                if (pending_items.size() != 0 && pending_items[0].gap == 0)
                begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    func     <= nxt.fn;
                    in_char  <= nxt.ch;
                end
                else
                begin
                    in_valid <= 1'b0;
                    tx_wait  <= (pending_items.size() != 0) ? pending_items[0].gap - 1 : 0;
                end
            end
            else if (!in_valid)
            begin
                if (tx_wait != 0)
                    tx_wait <= tx_wait - 1;
                else if (pending_items.size() != 0)
                begin
                    nxt = pending_items.pop_front();
                    in_valid <= 1'b1;
                    func     <= nxt.fn;
                    in_char  <= nxt.ch;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver pacing: random stall after each transfer, no-stall stretches,
    // and two long hold-offs so the block backs up into its input
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : pace_receiver
        int unsigned w;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                drained <= drained + 1;
                if (drained == 250 || drained == 800)
                    w = HOLD_OFF;
                else if ((drained / 128) % 4 == 1)
                    w = 0;
                else
                    w = $urandom_range(0, MAX_GAP);
                rx_wait   <= w;
                out_stall <= (w != 0);
            end
            else if (rx_wait > 1)
                rx_wait <= rx_wait - 1;
            else if (rx_wait == 1)
            begin
                rx_wait   <= 0;
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: check each result against the oldest expectation,
    // then predict from the input transfer at the same edge
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        logic [7:0] want;
        if (!rst_n)
        begin
            // identity alphabet, nothing placed
            for (int i = 0; i < kwsc_pkg::ALPHABET_LETTERS; i++)
            begin
                alpha_fwd[i] = kwsc_pkg::IDX_W'(i);
                alpha_inv[i] = kwsc_pkg::IDX_W'(i);
            end
            key_used = '0;
            key_fill = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: out_char expected none, got %02h", $time, out_char);
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (out_char !== want)
                    begin
                        $display("%0t: out_char expected %02h, got %02h", $time, want, out_char);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_cipher_item(func, in_char);
        end
    end

    // ---------------------------------------------------------------
    // watchdog
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("keyword_substitution_cipher_top_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // end of run: all items sent, all results back, then a drain window
    // ---------------------------------------------------------------

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_text.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (expected_text.size() != 0)
            $display("%0t: %0d results expected, 0 arrived", $time, expected_text.size());
        if (mismatches == 0 && expected_text.size() == 0)
            $display("keyword_substitution_cipher_top_tb passed");
        else
            $display("keyword_substitution_cipher_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
